/* hdl/ntg_pkg.sv */
package ntg_pkg;

    localparam int MODULUS_BITS = 15;
    localparam int MAX_POINTS   = 32;
    localparam int PTS_BITS     = 6;
    localparam int CNT_BITS     = $clog2(MODULUS_BITS);

    typedef struct packed {
        logic [MODULUS_BITS-1:0] modulus;
        logic [PTS_BITS-1:0]     points;
    } t_in_item;

    typedef struct packed {
        logic [PTS_BITS-1:0]     index;
        logic [MODULUS_BITS-1:0] value;
        logic                    last;
        logic                    error;
    } t_out_item;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV,
        ST_ERR,
        ST_CAND,
        ST_STEP,
        ST_STEP_WAIT,
        ST_POW,
        ST_POW_ACC,
        ST_POW_SQ,
        ST_POW_SQ_WAIT,
        ST_EMIT,
        ST_EMIT_MUL,
        ST_EMIT_WAIT
    } t_state;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_DIV_START,
        OP_SEARCH_INIT,
        OP_CAND_NEXT,
        OP_STEP_INIT,
        OP_STEP_WB,
        OP_POW_INIT_GEN,
        OP_POW_INIT_ZERO,
        OP_ACC_WB,
        OP_SQ_WB,
        OP_EMIT_INIT,
        OP_EMIT_OUT,
        OP_EMIT_WB,
        OP_ERR_OUT,
        OP_MUL_START
    } t_dp_op;

    typedef enum logic [1:0] {
        MUL_STEP,
        MUL_ACC,
        MUL_SQ,
        MUL_EMIT
    } t_mul_sel;

    typedef struct packed {
        t_dp_op   op;
        t_mul_sel sel;
    } t_dp_cmd;

    typedef struct packed {
        logic p_small;
        logic n_bad;
        logic div_done;
        logic rem_nz;
        logic cand_end;
        logic step_end;
        logic x_one;
        logic e_zero;
        logic e_odd;
        logic mul_done;
        logic idx_last;
    } t_dp_sts;

endpackage

/* hdl/ntt_twiddle_table_generator.sv */
// channel   ports                        handshake
// request   i_item (modulus, points)     taken when start is high and busy is low
// result    o_result (index, value,      o_strobe high for one cycle per item,
//           last, error)                 taken at the edge that ends that cycle
//
// a modular multiply runs in the serial multiplier, which the search steps, the
//   power and the table walk share
// the generator search tries successive powers of each candidate until it finds one
//   whose powers do not return to one below p-1
// a request is rejected for a bad range or for a size not dividing p-1
// reset is synchronous, active low, and returns the controller to idle
// results cannot be held off; busy falls as the last item is strobed, so the
//   next request can be taken at the edge that ends that strobe cycle
module ntt_twiddle_table_generator (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  ntg_pkg::t_in_item  i_item,
    output logic               o_strobe,
    output ntg_pkg::t_out_item o_result
);
    import ntg_pkg::*;

    // command and status between sequencer and arithmetic
    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    // sequencer: range check, divide, generator search, pow, table walk
    ntg_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_sts    (w_sts),
        .o_cmd    (w_cmd),
        .o_busy   (busy),
        .o_strobe (o_strobe)
    );

    // registers, serial divider, serial modular multiplier, output register
    ntg_datapath u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_item),
        .i_cmd    (w_cmd),
        .o_sts    (w_sts),
        .o_result (o_result)
    );

endmodule

/* hdl/ntg_modmul.sv */
module ntg_modmul (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic [ntg_pkg::MODULUS_BITS-1:0] i_a,
    input  logic [ntg_pkg::MODULUS_BITS-1:0] i_b,
    input  logic [ntg_pkg::MODULUS_BITS-1:0] i_p,
    output logic                             o_done,
    output logic [ntg_pkg::MODULUS_BITS-1:0] o_prod
);
    import ntg_pkg::*;

    // interleaved multiply, msb of b first; operands must be below p
    logic                    r_busy;
    logic                    r_done;
    logic [CNT_BITS-1:0]     r_cnt;
    logic [MODULUS_BITS-1:0] r_acc;
    logic [MODULUS_BITS-1:0] r_a;
    logic [MODULUS_BITS-1:0] r_b;
    logic [MODULUS_BITS-1:0] r_p;
    logic [MODULUS_BITS:0]   w_dbl;
    logic [MODULUS_BITS:0]   w_sum;
    logic [MODULUS_BITS-1:0] n_acc;

    always_comb begin
        w_dbl = {r_acc, 1'b0};
        if (w_dbl >= {1'b0, r_p}) begin
            w_dbl = w_dbl - {1'b0, r_p};
        end
        w_sum = w_dbl + (r_b[MODULUS_BITS-1] ? {1'b0, r_a} : '0);
        if (w_sum >= {1'b0, r_p}) begin
            w_sum = w_sum - {1'b0, r_p};
        end
        n_acc = w_sum[MODULUS_BITS-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_cnt <= CNT_BITS'(MODULUS_BITS - 1);
            r_acc <= '0;
            r_a   <= i_a;
            r_b   <= i_b;
            r_p   <= i_p;
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            r_acc <= n_acc;
            r_b   <= {r_b[MODULUS_BITS-2:0], 1'b0};
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule

/* hdl/ntg_div.sv */
module ntg_div (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic [ntg_pkg::MODULUS_BITS-1:0] i_dividend,
    input  logic [ntg_pkg::PTS_BITS-1:0]     i_divisor,
    output logic                             o_done,
    output logic [ntg_pkg::MODULUS_BITS-1:0] o_quot,
    output logic [ntg_pkg::PTS_BITS-1:0]     o_rem
);
    import ntg_pkg::*;

    // restoring division, one quotient bit per cycle
    logic                    r_busy;
    logic                    r_done;
    logic [CNT_BITS-1:0]     r_cnt;
    logic [MODULUS_BITS-1:0] r_quot;
    logic [PTS_BITS-1:0]     r_rem;
    logic [PTS_BITS-1:0]     r_dvs;
    logic [PTS_BITS:0]       w_trial;
    logic [PTS_BITS:0]       w_diff;
    logic                    w_qbit;

    always_comb begin
        w_trial = {r_rem, r_quot[MODULUS_BITS-1]};
        w_qbit  = (w_trial >= {1'b0, r_dvs});
        w_diff  = w_qbit ? (w_trial - {1'b0, r_dvs}) : w_trial;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_cnt  <= CNT_BITS'(MODULUS_BITS - 1);
            r_quot <= i_dividend;
            r_rem  <= '0;
            r_dvs  <= i_divisor;
        end else if (r_busy) begin
            r_cnt  <= r_cnt - 1'b1;
            r_quot <= {r_quot[MODULUS_BITS-2:0], w_qbit};
            r_rem  <= w_diff[PTS_BITS-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
    assign o_rem  = r_rem;

endmodule

/* hdl/ntg_datapath.sv */
module ntg_datapath (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ntg_pkg::t_in_item  i_item,
    input  ntg_pkg::t_dp_cmd   i_cmd,
    output ntg_pkg::t_dp_sts   o_sts,
    output ntg_pkg::t_out_item o_result
);
    import ntg_pkg::*;

    logic [MODULUS_BITS-1:0] r_p;
    logic [PTS_BITS-1:0]     r_n;
    logic [MODULUS_BITS-1:0] r_e;
    logic [MODULUS_BITS-1:0] r_cand;
    logic [MODULUS_BITS-1:0] r_x;
    logic [MODULUS_BITS-1:0] r_k;
    logic [MODULUS_BITS-1:0] r_acc;
    logic [MODULUS_BITS-1:0] r_b;
    logic [MODULUS_BITS-1:0] r_cur;
    logic [PTS_BITS-1:0]     r_idx;
    t_out_item               r_out;

    logic [MODULUS_BITS-1:0] w_mul_a;
    logic [MODULUS_BITS-1:0] w_mul_b;
    logic                    w_mul_done;
    logic [MODULUS_BITS-1:0] w_prod;
    logic                    w_div_done;
    logic [MODULUS_BITS-1:0] w_quot;
    logic [PTS_BITS-1:0]     w_rem;

    always_comb begin
        case (i_cmd.sel)
            MUL_STEP: begin
                w_mul_a = r_x;
                w_mul_b = r_cand;
            end
            MUL_ACC: begin
                w_mul_a = r_acc;
                w_mul_b = r_b;
            end
            MUL_SQ: begin
                w_mul_a = r_b;
                w_mul_b = r_b;
            end
            default: begin
                w_mul_a = r_cur;
                w_mul_b = r_acc;
            end
        endcase
    end

    ntg_modmul u_modmul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.op == OP_MUL_START),
        .i_a     (w_mul_a),
        .i_b     (w_mul_b),
        .i_p     (r_p),
        .o_done  (w_mul_done),
        .o_prod  (w_prod)
    );

    ntg_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.op == OP_DIV_START),
        .i_dividend (r_p - 1'b1),
        .i_divisor  (r_n),
        .o_done     (w_div_done),
        .o_quot     (w_quot),
        .o_rem      (w_rem)
    );

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LOAD: begin
                r_p <= i_item.modulus;
                r_n <= i_item.points;
            end
            OP_SEARCH_INIT: begin
                r_e    <= w_quot;
                r_cand <= MODULUS_BITS'(2);
            end
            OP_CAND_NEXT: begin
                r_cand <= r_cand + 1'b1;
            end
            OP_STEP_INIT: begin
                r_x <= r_cand;
                r_k <= MODULUS_BITS'(1);
            end
            OP_STEP_WB: begin
                r_x <= w_prod;
                r_k <= r_k + 1'b1;
            end
            OP_POW_INIT_GEN: begin
                r_acc <= MODULUS_BITS'(1);
                r_b   <= r_cand;
            end
            OP_POW_INIT_ZERO: begin
                r_acc <= MODULUS_BITS'(1);
                r_b   <= '0;
            end
            OP_ACC_WB: begin
                r_acc <= w_prod;
            end
            OP_SQ_WB: begin
                r_b <= w_prod;
                r_e <= r_e >> 1;
            end
            OP_EMIT_INIT: begin
                r_cur <= MODULUS_BITS'(1);
                r_idx <= '0;
            end
            OP_EMIT_OUT: begin
                r_out.index <= r_idx;
                r_out.value <= r_cur;
                r_out.last  <= (r_idx == r_n);
                r_out.error <= 1'b0;
            end
            OP_EMIT_WB: begin
                r_cur <= w_prod;
                r_idx <= r_idx + 1'b1;
            end
            OP_ERR_OUT: begin
                r_out.index <= '0;
                r_out.value <= '0;
                r_out.last  <= 1'b1;
                r_out.error <= 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        o_sts.p_small  = (r_p < MODULUS_BITS'(2));
        o_sts.n_bad    = (r_n == '0) || (r_n > PTS_BITS'(MAX_POINTS));
        o_sts.div_done = w_div_done;
        o_sts.rem_nz   = (w_rem != '0);
        o_sts.cand_end = (r_cand >= r_p);
        o_sts.step_end = (({1'b0, r_k} + 1'b1) >= {1'b0, r_p});
        o_sts.x_one    = (r_x == MODULUS_BITS'(1));
        o_sts.e_zero   = (r_e == '0);
        o_sts.e_odd    = r_e[0];
        o_sts.mul_done = w_mul_done;
        o_sts.idx_last = (r_idx == r_n);
    end

    assign o_result = r_out;

endmodule

/* hdl/ntg_ctrl.sv */
module ntg_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  ntg_pkg::t_dp_sts i_sts,
    output ntg_pkg::t_dp_cmd o_cmd,
    output logic             o_busy,
    output logic             o_strobe
);
    import ntg_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_strobe;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= (o_cmd.op == OP_EMIT_OUT) || (o_cmd.op == OP_ERR_OUT);
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_state = ST_CHECK;
                end
            end
            ST_CHECK: begin
                n_state = (i_sts.p_small || i_sts.n_bad) ? ST_ERR : ST_DIV;
            end
            ST_DIV: begin
                if (i_sts.div_done) begin
                    n_state = i_sts.rem_nz ? ST_ERR : ST_CAND;
                end
            end
            ST_ERR: begin
                n_state = ST_IDLE;
            end
            ST_CAND: begin
                n_state = i_sts.cand_end ? ST_POW : ST_STEP;
            end
            ST_STEP: begin
                if (i_sts.step_end) begin
                    n_state = ST_POW;
                end else if (i_sts.x_one) begin
                    n_state = ST_CAND;
                end else begin
                    n_state = ST_STEP_WAIT;
                end
            end
            ST_STEP_WAIT: begin
                if (i_sts.mul_done) begin
                    n_state = ST_STEP;
                end
            end
            ST_POW: begin
                if (i_sts.e_zero) begin
                    n_state = ST_EMIT;
                end else if (i_sts.e_odd) begin
                    n_state = ST_POW_ACC;
                end else begin
                    n_state = ST_POW_SQ;
                end
            end
            ST_POW_ACC: begin
                if (i_sts.mul_done) begin
                    n_state = ST_POW_SQ;
                end
            end
            ST_POW_SQ: begin
                n_state = ST_POW_SQ_WAIT;
            end
            ST_POW_SQ_WAIT: begin
                if (i_sts.mul_done) begin
                    n_state = ST_POW;
                end
            end
            ST_EMIT: begin
                n_state = i_sts.idx_last ? ST_IDLE : ST_EMIT_MUL;
            end
            ST_EMIT_MUL: begin
                n_state = ST_EMIT_WAIT;
            end
            ST_EMIT_WAIT: begin
                if (i_sts.mul_done) begin
                    n_state = ST_EMIT;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // datapath commands
    always_comb begin
        o_cmd.op  = OP_NONE;
        o_cmd.sel = MUL_STEP;
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    o_cmd.op = OP_LOAD;
                end
            end
            ST_CHECK: begin
                if (!(i_sts.p_small || i_sts.n_bad)) begin
                    o_cmd.op = OP_DIV_START;
                end
            end
            ST_DIV: begin
                if (i_sts.div_done && !i_sts.rem_nz) begin
                    o_cmd.op = OP_SEARCH_INIT;
                end
            end
            ST_ERR: begin
                o_cmd.op = OP_ERR_OUT;
            end
            ST_CAND: begin
                o_cmd.op = i_sts.cand_end ? OP_POW_INIT_ZERO : OP_STEP_INIT;
            end
            ST_STEP: begin
                if (i_sts.step_end) begin
                    o_cmd.op = OP_POW_INIT_GEN;
                end else if (i_sts.x_one) begin
                    o_cmd.op = OP_CAND_NEXT;
                end else begin
                    o_cmd.op  = OP_MUL_START;
                    o_cmd.sel = MUL_STEP;
                end
            end
            ST_STEP_WAIT: begin
                if (i_sts.mul_done) begin
                    o_cmd.op = OP_STEP_WB;
                end
            end
            ST_POW: begin
                if (i_sts.e_zero) begin
                    o_cmd.op = OP_EMIT_INIT;
                end else if (i_sts.e_odd) begin
                    o_cmd.op  = OP_MUL_START;
                    o_cmd.sel = MUL_ACC;
                end
            end
            ST_POW_ACC: begin
                if (i_sts.mul_done) begin
                    o_cmd.op = OP_ACC_WB;
                end
            end
            ST_POW_SQ: begin
                o_cmd.op  = OP_MUL_START;
                o_cmd.sel = MUL_SQ;
            end
            ST_POW_SQ_WAIT: begin
                if (i_sts.mul_done) begin
                    o_cmd.op = OP_SQ_WB;
                end
            end
            ST_EMIT: begin
                o_cmd.op = OP_EMIT_OUT;
            end
            ST_EMIT_MUL: begin
                o_cmd.op  = OP_MUL_START;
                o_cmd.sel = MUL_EMIT;
            end
            ST_EMIT_WAIT: begin
                if (i_sts.mul_done) begin
                    o_cmd.op = OP_EMIT_WB;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_busy   = (r_state != ST_IDLE);
    assign o_strobe = r_strobe;

endmodule
